>>> hdl/mefs_pkg.sv
// ----------------------------------------------------------------------------
// mefs_pkg
// Shared types and constants for the epilogue frame scanner.
// ----------------------------------------------------------------------------
package mefs_pkg;

  localparam int unsigned AddrW   = 30;
  localparam int unsigned InstrW  = 32;
  localparam int unsigned ImmW    = 16;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned InDataW  = 64;  // addr + instr, byte padded
  localparam int unsigned OutDataW = 56;  // 16 + 32 + 1 + 1, byte padded

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [AddrW-1:0] EndWordReset = 30'd8126464;

  localparam logic [InstrW-1:0] OpMask     = 32'hffff0000;
  localparam logic [InstrW-1:0] OpLwRa     = 32'h8fbf0000;
  localparam logic [InstrW-1:0] OpLdRa     = 32'hdfbf0000;
  localparam logic [InstrW-1:0] OpLqRa     = 32'h7bbf0000;
  localparam logic [InstrW-1:0] OpAddiuSp  = 32'h27bd0000;
  localparam logic [InstrW-1:0] OpAdduSp   = 32'h03a1e821;
  localparam logic [InstrW-1:0] OpLuiAt    = 32'h3c010000;
  localparam logic [InstrW-1:0] OpOriAtAt  = 32'h34210000;
  localparam logic [InstrW-1:0] OpOriAtZr  = 32'h34010000;
  localparam logic [InstrW-1:0] OpJrRa     = 32'h03e00008;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_RELOAD,
    KIND_ADDIU,
    KIND_ADDU,
    KIND_LUI,
    KIND_ORI_AT,
    KIND_ORI_ZERO,
    KIND_JR
  } kind_e;

  // One classified word as it sits in the queue.
  typedef struct packed {
    logic            start;
    kind_e           kind;
    logic [ImmW-1:0] imm;
    logic            past_end;   // word_addr >= end word
    logic            last_word;  // word_addr + 1 >= end word
  } item_t;

  typedef struct packed {
    logic              found_reload;
    logic              frame_ok;
    logic [SizeW-1:0]  frame_size;
    logic [ImmW-1:0]   reload_off;
  } result_t;

endpackage

>>> hdl/mefs_front.sv
// ----------------------------------------------------------------------------
// mefs_front
// Holds the end-word register and classifies each incoming instruction word.
// ----------------------------------------------------------------------------
module mefs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mefs_pkg::AddrW-1:0]  cfg_wdata_i,
  input  logic                        start_req_i,
  input  logic [mefs_pkg::AddrW-1:0]  word_addr_i,
  input  logic [mefs_pkg::InstrW-1:0] instr_i,
  output mefs_pkg::item_t             item_o
);

  logic [mefs_pkg::AddrW-1:0]  end_word_q;
  logic [mefs_pkg::InstrW-1:0] op_hi;
  logic [mefs_pkg::AddrW:0]    addr_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_word_q <= mefs_pkg::EndWordReset;
    end else if (cfg_we_i) begin
      end_word_q <= cfg_wdata_i;
    end
  end

  assign op_hi    = instr_i & mefs_pkg::OpMask;
  assign addr_inc = {1'b0, word_addr_i} + {{mefs_pkg::AddrW{1'b0}}, 1'b1};

  always_comb begin
    item_o.start     = start_req_i;
    item_o.imm       = instr_i[mefs_pkg::ImmW-1:0];
    item_o.past_end  = (word_addr_i >= end_word_q);
    item_o.last_word = (addr_inc >= {1'b0, end_word_q});
    // same priority as the scan applies
    if (op_hi == mefs_pkg::OpLwRa || op_hi == mefs_pkg::OpLdRa ||
        op_hi == mefs_pkg::OpLqRa) begin
      item_o.kind = mefs_pkg::KIND_RELOAD;
    end else if (op_hi == mefs_pkg::OpAddiuSp) begin
      item_o.kind = mefs_pkg::KIND_ADDIU;
    end else if (instr_i == mefs_pkg::OpAdduSp) begin
      item_o.kind = mefs_pkg::KIND_ADDU;
    end else if (op_hi == mefs_pkg::OpLuiAt) begin
      item_o.kind = mefs_pkg::KIND_LUI;
    end else if (op_hi == mefs_pkg::OpOriAtAt) begin
      item_o.kind = mefs_pkg::KIND_ORI_AT;
    end else if (op_hi == mefs_pkg::OpOriAtZr) begin
      item_o.kind = mefs_pkg::KIND_ORI_ZERO;
    end else if (instr_i == mefs_pkg::OpJrRa) begin
      item_o.kind = mefs_pkg::KIND_JR;
    end else begin
      item_o.kind = mefs_pkg::KIND_NONE;
    end
  end

endmodule

>>> hdl/mefs_queue.sv
// ----------------------------------------------------------------------------
// mefs_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module mefs_queue #(
  parameter int unsigned Depth = mefs_pkg::QueueDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  mefs_pkg::item_t           push_item_i,
  input  logic                      pop_i,
  output mefs_pkg::item_t           head_o,
  output logic                      full_o,
  output logic                      empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  mefs_pkg::item_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> hdl/mefs_back.sv
// ----------------------------------------------------------------------------
// mefs_back
// Scan state: applies classified words, detects the end of a scan and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module mefs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  mefs_pkg::item_t  item_i,
  output logic             item_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output mefs_pkg::result_t res_o
);

  logic                        active_q, active_d;
  logic                        seen_rel_q, seen_rel_d;
  logic                        seen_adj_q, seen_adj_d;
  logic                        seen_up_q, seen_up_d;
  logic                        seen_lo_q, seen_lo_d;
  logic [mefs_pkg::ImmW-1:0]   upper_q, upper_d;
  logic [mefs_pkg::ImmW-1:0]   lower_q, lower_d;
  logic [mefs_pkg::ImmW-1:0]   reload_q, reload_d;
  logic [mefs_pkg::SizeW-1:0]  adjust_q, adjust_d;
  logic                        slot_q, slot_d;
  logic                        was_slot, finish;
  logic                        res_valid_q;
  mefs_pkg::result_t           res_q, res_d;
  logic [mefs_pkg::SizeW-1:0]  size;

  assign item_pop_o  = item_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    active_d   = active_q;
    seen_rel_d = seen_rel_q;
    seen_adj_d = seen_adj_q;
    seen_up_d  = seen_up_q;
    seen_lo_d  = seen_lo_q;
    upper_d    = upper_q;
    lower_d    = lower_q;
    reload_d   = reload_q;
    adjust_d   = adjust_q;
    slot_d     = slot_q;
    was_slot   = 1'b0;
    finish     = 1'b0;
    if (item_pop_o) begin
      if (item_i.start) begin
        active_d   = 1'b1;
        seen_rel_d = 1'b0;
        seen_adj_d = 1'b0;
        seen_up_d  = 1'b0;
        seen_lo_d  = 1'b0;
        upper_d    = '0;
        lower_d    = '0;
        reload_d   = '0;
        adjust_d   = '1;
        slot_d     = 1'b0;
      end
      if (active_d) begin
        if (!slot_d && item_i.past_end) begin
          finish = 1'b1;
        end else begin
          was_slot = slot_d;
          case (item_i.kind)
            mefs_pkg::KIND_RELOAD: begin
              reload_d   = item_i.imm;
              seen_rel_d = 1'b1;
            end
            mefs_pkg::KIND_ADDIU: begin
              adjust_d   = {{(mefs_pkg::SizeW-mefs_pkg::ImmW){item_i.imm[mefs_pkg::ImmW-1]}},
                            item_i.imm};
              seen_adj_d = 1'b1;
            end
            mefs_pkg::KIND_ADDU: begin
              adjust_d   = '0;
              seen_adj_d = 1'b1;
            end
            mefs_pkg::KIND_LUI: begin
              upper_d   = item_i.imm;
              lower_d   = '0;
              seen_up_d = 1'b1;
            end
            mefs_pkg::KIND_ORI_AT: begin
              lower_d   = item_i.imm;
              seen_lo_d = 1'b1;
            end
            mefs_pkg::KIND_ORI_ZERO: begin
              lower_d   = item_i.imm;
              upper_d   = '0;
              seen_lo_d = 1'b1;
            end
            default: ;
          endcase
          if (seen_rel_d && seen_adj_d) begin
            finish = 1'b1;
          end else if (item_i.kind == mefs_pkg::KIND_JR) begin
            slot_d = 1'b1;
          end else if (was_slot || item_i.last_word) begin
            finish = 1'b1;
          end
        end
        if (finish) begin
          active_d = 1'b0;
        end
      end
    end
  end

  // addu form: size comes from the lui/ori pair
  always_comb begin
    size = adjust_d;
    if (adjust_d == '0 && (seen_up_d || seen_lo_d)) begin
      size = {upper_d, lower_d};
    end
    res_d.reload_off   = reload_d;
    res_d.frame_size   = size;
    res_d.frame_ok     = (size != '0) && !size[mefs_pkg::SizeW-1];
    res_d.found_reload = seen_rel_d;
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      seen_rel_q  <= 1'b0;
      seen_adj_q  <= 1'b0;
      seen_up_q   <= 1'b0;
      seen_lo_q   <= 1'b0;
      upper_q     <= '0;
      lower_q     <= '0;
      reload_q    <= '0;
      adjust_q    <= '1;
      slot_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      active_q   <= active_d;
      seen_rel_q <= seen_rel_d;
      seen_adj_q <= seen_adj_d;
      seen_up_q  <= seen_up_d;
      seen_lo_q  <= seen_lo_d;
      upper_q    <= upper_d;
      lower_q    <= lower_d;
      reload_q   <= reload_d;
      adjust_q   <= adjust_d;
      slot_q     <= slot_d;
      if (finish) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/mips_epilogue_frame_scanner.sv
// ----------------------------------------------------------------------------
// mips_epilogue_frame_scanner
// Scans MIPS instruction words for a function epilogue and reports the
// return-address slot offset and the frame size.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tuser: start_req; tdata: addr, instr
// m_axis    out  m_axis_tvalid/tready        tdata: offset, size, ok, found
// cfg       in   cfg_we_i (no stall)         cfg_wdata_i: scan end word
//
// One word per cycle sustained while m_axis is not stalled: the front decodes
// in the accept cycle, the back applies one queued word per cycle. Results are
// held in the back's output register. A stalled m_axis stops the back; the
// queue (QueueDepth entries) then fills and drops s_axis_tready. Reset clears
// all control state; the end word returns to 0x7c0000.
// ----------------------------------------------------------------------------
module mips_epilogue_frame_scanner #(
  parameter int unsigned QueueDepth = mefs_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mefs_pkg::AddrW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [29:0] word_addr, [61:30] instr, [63:62] zero
  input  logic [mefs_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] start_req
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] reload_off, [47:16] frame_size, [48] frame_ok, [49] found_reload,
  // [55:50] zero
  output logic [mefs_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(QueueDepth+1);

  mefs_pkg::item_t   front_item, head_item;
  mefs_pkg::result_t result;
  logic              q_full, q_empty, push, pop;
  logic [CntW-1:0]   q_count;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  mefs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_req_i (s_axis_tuser),
    .word_addr_i (s_axis_tdata[mefs_pkg::AddrW-1:0]),
    .instr_i     (s_axis_tdata[mefs_pkg::AddrW +: mefs_pkg::InstrW]),
    .item_o      (front_item)
  );

  mefs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  mefs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_empty),
    .item_i       (head_item),
    .item_pop_o   (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (result)
  );

  assign m_axis_tdata = {{(mefs_pkg::OutDataW - $bits(mefs_pkg::result_t)){1'b0}}, result};

  // queue occupancy tracks transactions in and out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (q_count == $past(q_count) + CntW'($past(push)) - CntW'($past(pop))))
    else $error("queue count out of step with push/pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[48] ==
      (m_axis_tdata[47:16] != '0 && !m_axis_tdata[47])))
    else $error("frame_ok does not match frame_size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[49]) |-> (m_axis_tdata[15:0] == '0))
    else $error("reload offset set without a reload");

endmodule

>>> tb/mips_epilogue_frame_scanner_tb.sv
// ----------------------------------------------------------------------------
// mips_epilogue_frame_scanner_tb
// Feeds instruction streams through the epilogue scanner and checks each
// reported frame against an in-bench decoder of the same epilogue rules,
// across several scan end words, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module mips_epilogue_frame_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the scan state and holds the frames still owed by the block.
  class frame_scoreboard;
    logic [mefs_pkg::AddrW-1:0] end_word;
    bit                         active;
    bit                         got_reload;
    bit                         got_adjust;
    bit                         got_upper;
    bit                         got_lower;
    bit                         slot_armed;
    logic [mefs_pkg::ImmW-1:0]  upper_imm;
    logic [mefs_pkg::ImmW-1:0]  lower_imm;
    logic [mefs_pkg::ImmW-1:0]  reload_imm;
    logic [mefs_pkg::SizeW-1:0] adjust;
    mefs_pkg::result_t          pending_frames[$];
    int unsigned                mismatches;

    function new();
      end_word   = mefs_pkg::EndWordReset;
      active     = 1'b0;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      got_reload = 1'b0;
      got_adjust = 1'b0;
      got_upper  = 1'b0;
      got_lower  = 1'b0;
      slot_armed = 1'b0;
      upper_imm  = '0;
      lower_imm  = '0;
      reload_imm = '0;
      adjust     = '1;
    endfunction

    function void close_scan();
      mefs_pkg::result_t          r;
      logic [mefs_pkg::SizeW-1:0] size;
      size = adjust;
      // addu $sp,$sp,$at: the size is whatever was built into $at
      if (size == '0 && (got_upper || got_lower)) size = {upper_imm, lower_imm};
      r.reload_off   = reload_imm;
      r.frame_size   = size;
      r.frame_ok     = (size != '0) && !size[mefs_pkg::SizeW-1];
      r.found_reload = got_reload;
      pending_frames.push_back(r);
      active = 1'b0;
    endfunction

    // Returns 1 when the word took part in a scan.
    function bit note_word(logic start, logic [mefs_pkg::AddrW-1:0] addr,
                           logic [mefs_pkg::InstrW-1:0] instr);
      logic [mefs_pkg::InstrW-1:0] hi;
      logic [mefs_pkg::ImmW-1:0]   imm;
      bit                          jr;
      bit                          was_slot;
      hi  = instr & mefs_pkg::OpMask;
      imm = instr[mefs_pkg::ImmW-1:0];
      jr  = 1'b0;
      if (start) begin
        clear();
        active = 1'b1;
      end
      if (!active) return 1'b0;
      if (!slot_armed && addr >= end_word) begin
        close_scan();
        return 1'b1;
      end
      if (hi == mefs_pkg::OpLwRa || hi == mefs_pkg::OpLdRa || hi == mefs_pkg::OpLqRa) begin
        reload_imm = imm;
        got_reload = 1'b1;
      end else if (hi == mefs_pkg::OpAddiuSp) begin
        adjust     = {{(mefs_pkg::SizeW-mefs_pkg::ImmW){imm[mefs_pkg::ImmW-1]}}, imm};
        got_adjust = 1'b1;
      end else if (instr == mefs_pkg::OpAdduSp) begin
        adjust     = '0;
        got_adjust = 1'b1;
      end else if (hi == mefs_pkg::OpLuiAt) begin
        upper_imm = imm;
        lower_imm = '0;
        got_upper = 1'b1;
      end else if (hi == mefs_pkg::OpOriAtAt) begin
        lower_imm = imm;
        got_lower = 1'b1;
      end else if (hi == mefs_pkg::OpOriAtZr) begin
        lower_imm = imm;
        upper_imm = '0;
        got_lower = 1'b1;
      end else if (instr == mefs_pkg::OpJrRa) begin
        jr = 1'b1;
      end
      if (got_reload && got_adjust) begin
        close_scan();
        return 1'b1;
      end
      was_slot = slot_armed;
      if (jr) begin
        slot_armed = 1'b1;
        return 1'b1;
      end
      if (was_slot || ({1'b0, addr} + 31'd1 >= {1'b0, end_word})) close_scan();
      return 1'b1;
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t MISMATCH %s: got %0h want %0h", $realtime, field, got, want);
      mismatches++;
    endtask

    task check_result(logic [mefs_pkg::OutDataW-1:0] data);
      mefs_pkg::result_t got;
      mefs_pkg::result_t want;
      got = data[$bits(mefs_pkg::result_t)-1:0];
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(data), '0);
        return;
      end
      want = pending_frames.pop_front();
      if (got.reload_off != want.reload_off)
        report_mismatch("reload_off", 64'(got.reload_off), 64'(want.reload_off));
      if (got.frame_size != want.frame_size)
        report_mismatch("frame_size", 64'(got.frame_size), 64'(want.frame_size));
      if (got.frame_ok != want.frame_ok)
        report_mismatch("frame_ok", 64'(got.frame_ok), 64'(want.frame_ok));
      if (got.found_reload != want.found_reload)
        report_mismatch("found_reload", 64'(got.found_reload), 64'(want.found_reload));
      if (data[mefs_pkg::OutDataW-1:$bits(mefs_pkg::result_t)] != '0)
        report_mismatch("tdata padding",
                        64'(data[mefs_pkg::OutDataW-1:$bits(mefs_pkg::result_t)]), '0);
    endtask
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [mefs_pkg::AddrW-1:0]    cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mefs_pkg::InDataW-1:0]  s_axis_tdata  = '0;  // [29:0] word_addr, [61:30] instr
  logic                          s_axis_tuser  = 1'b0;  // [0] start_req
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // [15:0] reload_off, [47:16] frame_size, [48] frame_ok, [49] found_reload
  logic [mefs_pkg::OutDataW-1:0] m_axis_tdata;

  frame_scoreboard sb = new();
  int unsigned     burst_left = 0;
  int unsigned     rx_cycle = 0;
  int unsigned     rx_mode = 0;

  mips_epilogue_frame_scanner u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: drives tready from a randomly drawn stall mode and checks each result taken.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_cycle % 8 != 5);
    endcase
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  function automatic logic [mefs_pkg::ImmW-1:0] rand_imm();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'hffff;
      4, 5: return 16'($urandom_range(1, 512) * 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mefs_pkg::kind_e pick_kind();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 12) return mefs_pkg::KIND_RELOAD;
    if (p < 24) return mefs_pkg::KIND_ADDIU;
    if (p < 30) return mefs_pkg::KIND_ADDU;
    if (p < 38) return mefs_pkg::KIND_LUI;
    if (p < 44) return mefs_pkg::KIND_ORI_AT;
    if (p < 50) return mefs_pkg::KIND_ORI_ZERO;
    if (p < 58) return mefs_pkg::KIND_JR;
    return mefs_pkg::KIND_NONE;
  endfunction

  function automatic logic [mefs_pkg::InstrW-1:0] make_instr(mefs_pkg::kind_e k,
                                                             logic [mefs_pkg::ImmW-1:0] imm);
    logic [mefs_pkg::InstrW-1:0] w;
    case (k)
      mefs_pkg::KIND_RELOAD: begin
        case ($urandom_range(0, 2))
          0: w = mefs_pkg::OpLwRa;
          1: w = mefs_pkg::OpLdRa;
          default: w = mefs_pkg::OpLqRa;
        endcase
        w = w | 32'(imm);
      end
      mefs_pkg::KIND_ADDIU:     w = mefs_pkg::OpAddiuSp | 32'(imm);
      mefs_pkg::KIND_ADDU:      w = mefs_pkg::OpAdduSp;
      mefs_pkg::KIND_LUI:       w = mefs_pkg::OpLuiAt | 32'(imm);
      mefs_pkg::KIND_ORI_AT:    w = mefs_pkg::OpOriAtAt | 32'(imm);
      mefs_pkg::KIND_ORI_ZERO:  w = mefs_pkg::OpOriAtZr | 32'(imm);
      mefs_pkg::KIND_JR:        w = mefs_pkg::OpJrRa;
      default: begin
        case ($urandom_range(0, 3))
          0: w = $urandom;
          1: w = '0;
          default: begin
            // near miss: a known pattern with one bit flipped
            case ($urandom_range(0, 4))
              0: w = mefs_pkg::OpLwRa;
              1: w = mefs_pkg::OpAddiuSp;
              2: w = mefs_pkg::OpLuiAt;
              3: w = mefs_pkg::OpAdduSp;
              default: w = mefs_pkg::OpJrRa;
            endcase
            w = w ^ (32'h1 << $urandom_range(0, 31));
          end
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic send_word(input logic start, input logic [mefs_pkg::AddrW-1:0] addr,
                           input logic [mefs_pkg::InstrW-1:0] instr, output bit counted);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, instr, addr};
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    counted = sb.note_word(start, addr, instr);
  endtask

  task automatic feed(input logic start, input logic [mefs_pkg::AddrW-1:0] addr,
                      input logic [mefs_pkg::InstrW-1:0] instr);
    bit counted;
    send_word(start, addr, instr, counted);
  endtask

  // Stop sending and let every owed frame come out; words that end no scan may
  // still sit in the block's queue, so wait on after that as well.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_scan_end(input logic [mefs_pkg::AddrW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.end_word = value;
  endtask

  task automatic run_scans(input int unsigned n);
    int unsigned                sent;
    int unsigned                cap;
    bit                         counted;
    logic [mefs_pkg::AddrW-1:0] addr;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 19) == 0) begin
        // stray word: ignored unless a scan is still running
        send_word(1'b0, 30'($urandom), 32'($urandom), counted);
        if (counted) sent++;
      end else begin
        case ($urandom_range(0, 9))
          0: addr = 30'($urandom);
          1, 2, 3: addr = sb.end_word - 30'($urandom_range(0, 6));
          default: addr = 30'($urandom_range(0, sb.end_word));
        endcase
        send_word(1'b1, addr, make_instr(pick_kind(), rand_imm()), counted);
        sent++;
        cap = $urandom_range(4, 24);
        while (sb.active && cap > 0 && sent < n) begin
          cap--;
          addr = ($urandom_range(0, 24) == 0) ? 30'($urandom) : addr + 30'd1;
          send_word($urandom_range(0, 39) == 0, addr, make_instr(pick_kind(), rand_imm()),
                    counted);
          if (counted) sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, default end word
    feed(1'b0, 30'd50, 32'h0);  // no scan running: ignored
    feed(1'b1, 30'd100, mefs_pkg::OpLwRa | 32'h0014);
    feed(1'b0, 30'd101, mefs_pkg::OpAddiuSp | 32'h0020);
    feed(1'b1, 30'd200, mefs_pkg::OpLdRa | 32'hffff);
    feed(1'b0, 30'd201, mefs_pkg::OpAddiuSp | 32'h8000);
    feed(1'b1, 30'd300, mefs_pkg::OpLqRa);
    feed(1'b0, 30'd301, mefs_pkg::OpLuiAt | 32'h0001);
    feed(1'b0, 30'd302, mefs_pkg::OpOriAtAt | 32'h2345);
    feed(1'b0, 30'd303, mefs_pkg::OpAdduSp);
    feed(1'b1, 30'd400, mefs_pkg::OpLuiAt | 32'h7fff);
    feed(1'b0, 30'd401, mefs_pkg::OpOriAtZr | 32'h8000);
    feed(1'b0, 30'd402, mefs_pkg::OpAdduSp);
    feed(1'b0, 30'd403, mefs_pkg::OpJrRa);
    feed(1'b0, 30'd404, 32'h0);
    feed(1'b1, 30'd500, 32'hffffffff);
    feed(1'b0, 30'd501, mefs_pkg::OpJrRa);
    feed(1'b0, 30'd502, mefs_pkg::OpJrRa);  // jump inside the delay slot
    feed(1'b0, 30'd503, 32'h0);
    feed(1'b1, 30'd600, mefs_pkg::OpAddiuSp);
    feed(1'b0, 30'd601, mefs_pkg::OpJrRa);
    feed(1'b0, 30'd602, mefs_pkg::OpAddiuSp | 32'hfff0);
    feed(1'b1, 30'h3fffffff, mefs_pkg::OpLwRa | 32'h0010);  // starts past the end
    feed(1'b1, mefs_pkg::EndWordReset - 30'd2, 32'h0);
    feed(1'b0, mefs_pkg::EndWordReset - 30'd1, mefs_pkg::OpJrRa);
    feed(1'b0, mefs_pkg::EndWordReset, mefs_pkg::OpLwRa | 32'h0008);  // slot past the end
    feed(1'b1, mefs_pkg::EndWordReset - 30'd1, 32'h0);

    run_scans(205);
    set_scan_end(30'd40);
    run_scans(205);
    set_scan_end('0);
    run_scans(150);
    set_scan_end('1);
    run_scans(205);
    set_scan_end(30'($urandom));
    run_scans(150);
    set_scan_end(mefs_pkg::EndWordReset);
    run_scans(160);

    drain();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
